// ===== design/assert_macros.svh =====
// Assertion macros shared by the stencil RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition at one edge implies a consequence at the next edge.
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/lap7_pkg.sv =====
// Shared constants and helpers for the seven point 3D Laplacian stream.
package lap7_pkg;

   localparam int DEF_MAX_NX      = 256;
   localparam int DEF_MAX_NY      = 256;
   localparam int DEF_MAX_NZ      = 256;
   localparam int DEF_SAMPLE_BITS = 24;

   localparam int LAP_BITS        = 28;
   localparam int CFG_BITS        = 9;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int SIZE_RESET      = 256;
   localparam int SIZE_MIN        = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Z = 2'd2;

   // Limits a programmed size to the range the buffers were built for.
   function automatic int clamp_size(input int value, input int hi);
      int result;
      if (value < SIZE_MIN) begin
         result = SIZE_MIN;
      end else if (value > hi) begin
         result = hi;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

// ===== design/lap7_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module lap7_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same address is written.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/laplacian_7pt_3d_stream.sv =====
// Top level of the streaming seven point 3D Laplacian stencil.
//
// Voxels arrive on the req_ channel in raster order, x fastest, one per beat.
// Every interior voxel yields one beat on the rsp_ channel carrying its
// Laplacian (six face neighbours minus six times the centre) and a flag that
// marks the final interior voxel of the volume; boundary voxels yield nothing.
// The result for a centre voxel is produced by the beat of the voxel one plane
// ahead of it; it passes stage one and the result register, then shows on rsp_valid.
// One voxel is taken every cycle while req_stall is low; that figure is set
// by the four RAM delay lines, each doing one read and one write per beat.
// Sizes are written on the csr_ port (x, y, z at indexes 0, 1, 2), always
// accepted, clamped to the built range; a size write restarts the volume at voxel
// zero. Reset gives 256 in each size and positions of zero. No clearing pass
// is needed: a buffered voxel is only read after it has been written.
// When the receiver stalls, the result register holds its beat and the block
// keeps taking voxels; the input is stalled only when a further interior
// result is also waiting behind the held one.
`include "assert_macros.svh"

module laplacian_7pt_3d_stream #(
   parameter int MAX_NX      = lap7_pkg::DEF_MAX_NX,
   parameter int MAX_NY      = lap7_pkg::DEF_MAX_NY,
   parameter int MAX_NZ      = lap7_pkg::DEF_MAX_NZ,
   parameter int SAMPLE_BITS = lap7_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lap7_pkg::LAP_BITS-1:0] rsp_lap_value,
   output logic                                 rsp_last_out,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lap7_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lap7_pkg::CFG_BITS-1:0]        csr_data
);

   import lap7_pkg::*;

   // Widths of sizes (which can hold the maximum) and of positions.
   localparam int NXW  = $clog2(MAX_NX + 1);
   localparam int NYW  = $clog2(MAX_NY + 1);
   localparam int NZW  = $clog2(MAX_NZ + 1);
   localparam int PXW  = $clog2(MAX_NX);
   localparam int PYW  = $clog2(MAX_NY);
   localparam int PZW  = $clog2(MAX_NZ);
   localparam int NXYW = $clog2(MAX_NX * MAX_NY + 1);

   // Delay line depths. Plane delay A covers one plane less one row, plane D one
   // voxel less, the row delays one row less the two voxels held in flip-flops.
   localparam int DEPTH_A = MAX_NX * (MAX_NY - 1);
   localparam int DEPTH_D = DEPTH_A - 1;
   localparam int DEPTH_B = MAX_NX - 2;
   localparam int AWA     = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
   localparam int AWD     = (DEPTH_D > 1) ? $clog2(DEPTH_D) : 1;
   localparam int AWB     = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;

   // Twelve sample magnitudes at most, so four guard bits suffice.
   localparam int SUMW = SAMPLE_BITS + 4;
   localparam int WIDE = (SUMW > LAP_BITS) ? SUMW : LAP_BITS;

   localparam logic signed [WIDE-1:0] SAT_HI =
      {{(WIDE - LAP_BITS + 1){1'b0}}, {(LAP_BITS - 1){1'b1}}};
   localparam logic signed [WIDE-1:0] SAT_LO =
      {{(WIDE - LAP_BITS + 1){1'b1}}, {(LAP_BITS - 1){1'b0}}};

   localparam int RESET_NX  = clamp_size(SIZE_RESET, MAX_NX);
   localparam int RESET_NY  = clamp_size(SIZE_RESET, MAX_NY);
   localparam int RESET_NZ  = clamp_size(SIZE_RESET, MAX_NZ);
   localparam int RESET_NXY = RESET_NX * RESET_NY;

   // Configuration and position state.
   logic [NXW-1:0]  nx_ff, nx_in;
   logic [NYW-1:0]  ny_ff, ny_in;
   logic [NZW-1:0]  nz_ff, nz_in;
   logic [NXYW-1:0] nxy_ff, nxy_in;
   logic [PXW-1:0]  pos_x_ff, pos_x_in;
   logic [PYW-1:0]  pos_y_ff, pos_y_in;
   logic [PZW-1:0]  pos_z_ff, pos_z_in;

   // Delay line pointers; both row delays share one period and one pointer.
   logic [AWA-1:0]  ptr_a_ff, ptr_a_in;
   logic [AWB-1:0]  ptr_b_ff, ptr_b_in;
   logic [AWD-1:0]  ptr_d_ff, ptr_d_in;
   logic [NXYW-1:0] a_last;
   logic [NXYW-1:0] d_last;
   logic [NXW-1:0]  b_last;

   // Handshake and pipeline control.
   logic            accept;
   logic            move1;
   logic            csr_we;
   logic            v1_ff, v1_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Raster position decode.
   logic            x_end, y_end, z_end;
   logic            interior;
   logic            last_voxel;
   logic [NXW-1:0]  clamp_x;
   logic [NYW-1:0]  clamp_y;
   logic [NZW-1:0]  clamp_z;

   // Stencil taps, all aligned to the voxel taken at the latest beat.
   logic signed [SAMPLE_BITS-1:0] up_ff;
   logic [SAMPLE_BITS-1:0]        yp_data;
   logic [SAMPLE_BITS-1:0]        xp_data;
   logic signed [SAMPLE_BITS-1:0] c_ff;
   logic signed [SAMPLE_BITS-1:0] xm_ff;
   logic [SAMPLE_BITS-1:0]        ym_data;
   logic [SAMPLE_BITS-1:0]        dn_data;
   logic                          last1_ff;

   // Arithmetic and result register.
   logic signed [SUMW-1:0]     sum;
   logic signed [WIDE-1:0]     sum_wide;
   logic signed [LAP_BITS-1:0] lap_sat;
   logic signed [LAP_BITS-1:0] rsp_lap_ff;
   logic                       rsp_last_ff;

   // A stage-one result may move when the result register is free or is
   // being emptied in this cycle. The input waits only while that result
   // is stuck, because the taps it was computed from would be overwritten.
   assign move1     = v1_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = v1_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   assign clamp_x = NXW'(clamp_size(int'(csr_data), MAX_NX));
   assign clamp_y = NYW'(clamp_size(int'(csr_data), MAX_NY));
   assign clamp_z = NZW'(clamp_size(int'(csr_data), MAX_NZ));

   assign x_end = (NXW'(pos_x_ff) == nx_ff - NXW'(1));
   assign y_end = (NYW'(pos_y_ff) == ny_ff - NYW'(1));
   assign z_end = (NZW'(pos_z_ff) == nz_ff - NZW'(1));

   // The arriving voxel is the upper neighbour of the centre one plane back.
   assign interior   = (pos_z_ff >= PZW'(2)) && (pos_x_ff != '0) && !x_end &&
                       (pos_y_ff != '0) && !y_end;
   assign last_voxel = (NXW'(pos_x_ff) == nx_ff - NXW'(2)) &&
                       (NYW'(pos_y_ff) == ny_ff - NYW'(2)) && z_end;

   // Periods: plane delay nxy - nx, second plane delay nxy - nx - 1, rows nx - 2.
   assign a_last = nxy_ff - NXYW'(nx_ff) - NXYW'(1);
   assign d_last = a_last - NXYW'(1);
   assign b_last = nx_ff - NXW'(3);

   always_comb begin
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      nz_in    = nz_ff;
      nxy_in   = nxy_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      ptr_a_in = ptr_a_ff;
      ptr_b_in = ptr_b_ff;
      ptr_d_in = ptr_d_ff;

      if (csr_we && (csr_index == CSR_SIZE_X || csr_index == CSR_SIZE_Y ||
                     csr_index == CSR_SIZE_Z)) begin
         // A size write starts a new volume and restarts the delay lines.
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
         ptr_a_in = '0;
         ptr_b_in = '0;
         ptr_d_in = '0;
         unique case (csr_index)
            CSR_SIZE_X: begin
               nx_in  = clamp_x;
               nxy_in = NXYW'(NXYW'(clamp_x) * NXYW'(ny_ff));
            end
            CSR_SIZE_Y: begin
               ny_in  = clamp_y;
               nxy_in = NXYW'(NXYW'(nx_ff) * NXYW'(clamp_y));
            end
            CSR_SIZE_Z: begin
               nz_in = clamp_z;
            end
            default: begin
               nz_in = nz_ff;
            end
         endcase
      end else if (accept) begin
         if (x_end) begin
            pos_x_in = '0;
            if (y_end) begin
               pos_y_in = '0;
               if (z_end) begin
                  pos_z_in = '0;
               end else begin
                  pos_z_in = pos_z_ff + PZW'(1);
               end
            end else begin
               pos_y_in = pos_y_ff + PYW'(1);
            end
         end else begin
            pos_x_in = pos_x_ff + PXW'(1);
         end

         if (NXYW'(ptr_a_ff) == a_last) begin
            ptr_a_in = '0;
         end else begin
            ptr_a_in = ptr_a_ff + AWA'(1);
         end
         if (NXYW'(ptr_d_ff) == d_last) begin
            ptr_d_in = '0;
         end else begin
            ptr_d_in = ptr_d_ff + AWD'(1);
         end
         if (NXW'(ptr_b_ff) == b_last) begin
            ptr_b_in = '0;
         end else begin
            ptr_b_in = ptr_b_ff + AWB'(1);
         end
      end
   end

   always_comb begin
      v1_in = v1_ff;
      if (accept) begin
         v1_in = interior;
      end else if (move1) begin
         v1_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (move1) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff        <= NXW'(RESET_NX);
         ny_ff        <= NYW'(RESET_NY);
         nz_ff        <= NZW'(RESET_NZ);
         nxy_ff       <= NXYW'(RESET_NXY);
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         ptr_d_ff     <= '0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nx_ff        <= nx_in;
         ny_ff        <= ny_in;
         nz_ff        <= nz_in;
         nxy_ff       <= nxy_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         ptr_d_ff     <= ptr_d_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Delay chain. Each RAM reads and overwrites the same slot on a beat, so
   // its registered output lags its input by the pointer period.
   lap7_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH_A)) u_plane_a (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ptr_a_ff),
      .wr_data (req_sample),
      .rd_en   (accept),
      .rd_addr (ptr_a_ff),
      .rd_data (yp_data)
   );

   lap7_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH_B)) u_row_b (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ptr_b_ff),
      .wr_data (yp_data),
      .rd_en   (accept),
      .rd_addr (ptr_b_ff),
      .rd_data (xp_data)
   );

   lap7_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH_B)) u_row_c (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ptr_b_ff),
      .wr_data (xm_ff),
      .rd_en   (accept),
      .rd_addr (ptr_b_ff),
      .rd_data (ym_data)
   );

   lap7_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH_D)) u_plane_d (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ptr_d_ff),
      .wr_data (ym_data),
      .rd_en   (accept),
      .rd_addr (ptr_d_ff),
      .rd_data (dn_data)
   );

   // The centre and the lower x neighbour sit in flip-flops between the rows.
   always_ff @(posedge clock) begin
      if (accept) begin
         up_ff    <= req_sample;
         c_ff     <= signed'(xp_data);
         xm_ff    <= c_ff;
         last1_ff <= last_voxel;
      end
   end

   // Six neighbours minus six times the centre, with six formed by shifts.
   assign sum = SUMW'(up_ff) + SUMW'(signed'(dn_data)) +
                SUMW'(xm_ff) + SUMW'(signed'(xp_data)) +
                SUMW'(signed'(ym_data)) + SUMW'(signed'(yp_data)) -
                ((SUMW'(c_ff) <<< 2) + (SUMW'(c_ff) <<< 1));

   assign sum_wide = WIDE'(sum);

   // Saturation only bites when the sample width is raised past the default.
   always_comb begin
      if (sum_wide > SAT_HI) begin
         lap_sat = SAT_HI[LAP_BITS-1:0];
      end else if (sum_wide < SAT_LO) begin
         lap_sat = SAT_LO[LAP_BITS-1:0];
      end else begin
         lap_sat = sum_wide[LAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         rsp_lap_ff  <= lap_sat;
         rsp_last_ff <= last1_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lap_value = rsp_lap_ff;
   assign rsp_last_out  = rsp_last_ff;

   // A result stuck in stage one keeps its taps: no voxel slips in under it.
   `ASSERT_NEXT(a_stage1_hold, v1_ff && !move1, v1_ff && $stable(up_ff),
                "stage one result lost its taps while blocked")
   // A size write restarts the raster position.
   `ASSERT_NEXT(a_cfg_restart, csr_we && csr_index != 2'd3,
                pos_x_ff == '0 && pos_y_ff == '0 && pos_z_ff == '0,
                "size write did not restart the volume")
   // Plane pointers stay inside their programmed periods.
   `ASSERT_CLK(a_ptr_range, NXYW'(ptr_a_ff) <= a_last && NXYW'(ptr_d_ff) <= d_last,
               "plane delay pointer beyond its period")
   // Voxels of the first two planes never produce a result.
   `ASSERT_NEXT(a_no_early, accept && pos_z_ff < PZW'(2), !v1_ff,
                "result raised before the lower plane was buffered")

endmodule
